/* hdl/tcp_option_field_extractor_assert.svh */
// Assertion macros used by the extractor RTL.
`ifndef TCP_OPTION_FIELD_EXTRACTOR_ASSERT_SVH
`define TCP_OPTION_FIELD_EXTRACTOR_ASSERT_SVH

// Clocked check, held off while reset is asserted.
`define OFE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tcp option extractor check failed");

// Clocked check that also holds during reset.
`define OFE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("tcp option extractor check failed");

`endif

/* hdl/tcp_ofe_pkg.sv */
package tcp_ofe_pkg;

	typedef struct packed {
		logic [7:0] opt_byte;
		logic       first;
		logic [5:0] area_len;
		logic       conn_match;
	} ofe_in_t;

	typedef struct packed {
		logic [1:0] target;
		logic [4:0] slot;
		logic [7:0] data_byte;
		logic       sack_clear;
		logic       md5_seen;
		logic       tfo_seen;
		logic       halted;
	} ofe_out_t;

	localparam logic [7:0] KIND_EOL  = 8'd0;
	localparam logic [7:0] KIND_NOP  = 8'd1;
	localparam logic [7:0] KIND_SACK = 8'd5;
	localparam logic [7:0] KIND_MD5  = 8'd19;
	localparam logic [7:0] KIND_TFO  = 8'd34;

	localparam logic [7:0] MD5_MIN_LEN    = 8'd18;
	localparam logic [5:0] MD5_DIGEST_LEN = 6'd16;
	localparam logic [7:0] TFO_MAX_COOKIE = 8'd8;

	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_SACK = 2'd1;
	localparam logic [1:0] TGT_MD5  = 2'd2;
	localparam logic [1:0] TGT_TFO  = 2'd3;

	localparam logic [5:0] AREA_POS_MAX = 6'd63;

endpackage

/* hdl/tcp_ofe_parse.sv */
module tcp_ofe_parse
	import tcp_ofe_pkg::*;
#(
	parameter int MAX_SACK_BLOCKS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  ofe_in_t  item,
	output ofe_out_t res
);

	typedef enum logic [1:0] {
		PH_KIND = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	phase_t     phase_q, phase_n, ph;
	logic [5:0] area_pos_q, area_pos_n, pos;
	logic [7:0] cur_kind_q, cur_kind_n;
	logic [7:0] cur_len_q, cur_len_n;
	logic [5:0] body_pos_q, body_pos_n, bp;
	logic [5:0] cap_lim_q, cap_lim_n, cl;
	logic       stopped_q, stopped_n, st;
	ofe_out_t   res_n;
	logic [7:0] blen;
	logic [4:0] nblk;
	logic [5:0] bp_inc;

	always_comb begin
		pos = item.first ? 6'd0 : area_pos_q;
		ph  = item.first ? PH_KIND : phase_q;
		bp  = item.first ? 6'd0 : body_pos_q;
		cl  = item.first ? 6'd0 : cap_lim_q;
		st  = item.first ? 1'b0 : stopped_q;

		area_pos_n = (pos < AREA_POS_MAX) ? pos + 6'd1 : pos;
		phase_n    = ph;
		cur_kind_n = cur_kind_q;
		cur_len_n  = cur_len_q;
		body_pos_n = bp;
		cap_lim_n  = cl;
		stopped_n  = st;
		res_n      = '0;

		blen   = item.opt_byte - 8'd2;
		nblk   = blen[7:3];
		bp_inc = bp + 6'd1;
		if (nblk > 5'(MAX_SACK_BLOCKS)) begin
			nblk = 5'(MAX_SACK_BLOCKS);
		end

		if (st || !item.conn_match || pos >= item.area_len) begin
			stopped_n = 1'b1;
		end else begin
			case (ph)
				PH_LEN: begin
					if (item.opt_byte < 8'd2 ||
					    ({1'b0, item.opt_byte} + {3'b0, pos}) >
					    ({3'b0, item.area_len} + 9'd1)) begin
						stopped_n = 1'b1;
					end else begin
						cur_len_n  = item.opt_byte;
						body_pos_n = 6'd0;
						cap_lim_n  = 6'd0;
						if (cur_kind_q == KIND_SACK) begin
							cap_lim_n        = {nblk[2:0], 3'b000};
							res_n.sack_clear = 1'b1;
						end else if (cur_kind_q == KIND_MD5) begin
							res_n.md5_seen = 1'b1;
							if (item.opt_byte >= MD5_MIN_LEN) begin
								cap_lim_n = MD5_DIGEST_LEN;
							end
						end else if (cur_kind_q == KIND_TFO) begin
							res_n.tfo_seen = 1'b1;
							cap_lim_n = (blen > TFO_MAX_COOKIE) ?
								TFO_MAX_COOKIE[5:0] : blen[5:0];
						end
						phase_n = (blen == 8'd0) ? PH_KIND : PH_BODY;
					end
				end
				PH_BODY: begin
					if (bp < cl) begin
						if (cur_kind_q == KIND_SACK) begin
							res_n.target = TGT_SACK;
						end else if (cur_kind_q == KIND_MD5) begin
							res_n.target = TGT_MD5;
						end else begin
							res_n.target = TGT_TFO;
						end
						res_n.slot      = bp[4:0];
						res_n.data_byte = item.opt_byte;
					end
					body_pos_n = bp_inc;
					if (({3'b0, bp_inc} + 9'd2) >= {1'b0, cur_len_q}) begin
						phase_n = PH_KIND;
					end
				end
				default: begin
					phase_n = PH_KIND;
					if (({1'b0, pos} + 7'd1) >= {1'b0, item.area_len} ||
					    item.opt_byte == KIND_EOL) begin
						stopped_n = 1'b1;
					end else if (item.opt_byte != KIND_NOP) begin
						cur_kind_n = item.opt_byte;
						phase_n    = PH_LEN;
					end
				end
			endcase
		end
		res_n.halted = stopped_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_KIND;
			area_pos_q <= '0;
			cur_kind_q <= '0;
			cur_len_q  <= '0;
			body_pos_q <= '0;
			cap_lim_q  <= '0;
			stopped_q  <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_n;
			area_pos_q <= area_pos_n;
			cur_kind_q <= cur_kind_n;
			cur_len_q  <= cur_len_n;
			body_pos_q <= body_pos_n;
			cap_lim_q  <= cap_lim_n;
			stopped_q  <= stopped_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res <= res_n;
		end
	end

endmodule

/* hdl/tcp_option_field_extractor.sv */
// TCP option field extractor.
// Input channel opt (opt_valid / opt_stall) carries one option-area byte per
// transfer with its first-byte flag, the area length and the connection match.
// Output channel fld (fld_valid / fld_stall) carries exactly one result per
// input byte, in order: capture target, slot and byte, the SACK / MD5 / Fast
// Open option flags, and whether parsing has halted for the rest of the area.
// A byte taken in passes through the input register and then the result
// register before it is presented as a result; an output stall holds it between.
// Throughput: one byte per cycle while fld_stall is low; the input register
// and the result register let a new byte enter while a result waits on the output.
// Reset clears all parser state and both valid flags; no result is pending.
// While the receiver stalls, the result holds; one more byte is taken into
// the input register, then opt_stall rises until the result is transferred.
// MAX_SACK_BLOCKS (1 to 4) bounds how many 8-byte SACK blocks are captured.
`include "tcp_option_field_extractor_assert.svh"

module tcp_option_field_extractor
	import tcp_ofe_pkg::*;
#(
	parameter int MAX_SACK_BLOCKS = 4
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     opt_valid,
	output logic     opt_stall,
	input  ofe_in_t  opt,
	output logic     fld_valid,
	input  logic     fld_stall,
	output ofe_out_t fld
);

	ofe_in_t    item_s1;
	logic       valid_s1;
	logic       fld_valid_q;
	logic       adv;
	logic       take;
	logic [2:0] opt_flags;

	assign adv       = valid_s1 && (!fld_valid_q || !fld_stall);
	assign opt_stall = valid_s1 && !adv;
	assign take      = opt_valid && !opt_stall;
	assign fld_valid = fld_valid_q;
	assign opt_flags = {fld.sack_clear, fld.md5_seen, fld.tfo_seen};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fld_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				fld_valid_q <= 1'b1;
			end else if (!fld_stall) begin
				fld_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= opt;
		end
	end

	tcp_ofe_parse #(
		.MAX_SACK_BLOCKS(MAX_SACK_BLOCKS)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (adv),
		.item  (item_s1),
		.res   (fld)
	);

	`OFE_ASSERT(a_one_flag, fld_valid_q |-> $onehot0(opt_flags))
	`OFE_ASSERT(a_flag_no_capture, fld_valid_q && |opt_flags |-> fld.target == TGT_NONE && !fld.halted)
	`OFE_ASSERT(a_capture_live, fld_valid_q && fld.target != TGT_NONE |-> !fld.halted)
	`OFE_ASSERT(a_md5_slot, fld_valid_q && fld.target == TGT_MD5 |-> !fld.slot[4])
	`OFE_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !fld_valid_q || $past(arst_n))

endmodule
